### rtl/lce_pkg.sv
// ----------------------------------------------------------------------------
// lce_pkg
// Shared types and constants for the Latin-1 composing encoder.
// ----------------------------------------------------------------------------
package lce_pkg;

   // Field widths
   localparam int CP_W   = 21;
   localparam int BYTE_W = 8;
   localparam int HELD_W = 7;

   // Result queue sizing
   localparam int QUEUE_DEPTH = 4;
   localparam int PTR_W       = $clog2(QUEUE_DEPTH);
   localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

   // Input kinds
   localparam logic KIND_CHAR  = 1'b0;
   localparam logic KIND_FLUSH = 1'b1;

   // Result status codes
   localparam logic STATUS_OK      = 1'b0;
   localparam logic STATUS_ILLEGAL = 1'b1;

   // Combining marks
   localparam logic [CP_W-1:0] MARK_GRAVE = CP_W'('h0300);
   localparam logic [CP_W-1:0] MARK_ACUTE = CP_W'('h0301);
   localparam logic [CP_W-1:0] MARK_CIRC  = CP_W'('h0302);
   localparam logic [CP_W-1:0] MARK_TILDE = CP_W'('h0303);
   localparam logic [CP_W-1:0] MARK_DIAER = CP_W'('h0308);
   localparam logic [CP_W-1:0] MARK_RING  = CP_W'('h030a);
   localparam logic [CP_W-1:0] MARK_CEDIL = CP_W'('h0327);

   // Code point ranges
   localparam logic [CP_W-1:0]   CP_SPACE    = CP_W'(32);
   localparam logic [CP_W-1:0]   CP_DEL      = CP_W'(127);
   localparam logic [CP_W-1:0]   CP_MAX      = CP_W'(255);
   localparam logic [HELD_W-1:0] HELD_NONE   = '0;

   // One result transaction
   typedef struct packed {
      logic [BYTE_W-1:0] out_byte;
      logic              status;
      logic              last;
   } result_type;

   // Up to two results produced by one input item, oldest in r0
   typedef struct packed {
      logic [1:0] cnt;
      result_type r0;
      result_type r1;
   } push_type;

endpackage

### rtl/lce_decode.sv
// ----------------------------------------------------------------------------
// lce_decode
// Input register, held-letter register and the single-pass composition logic.
// ----------------------------------------------------------------------------
module lce_decode (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  logic                          in_kind,
   input  logic [lce_pkg::CP_W-1:0]      in_cp,
   input  logic                          room,
   output lce_pkg::push_type             push
);

   // Look up a letter / mark pair; returns {found, composed byte}
   function automatic logic [8:0] compose_lookup(input logic [6:0] letter,
                                                 input logic [lce_pkg::CP_W-1:0] mark);
      logic       lower;
      logic [6:0] upper;
      logic       found;
      logic [7:0] comp;
      lower = (letter >= 7'h61) && (letter <= 7'h7a);
      upper = lower ? (letter - 7'h20) : letter;
      found = 1'b1;
      comp  = 8'h00;
      case (mark)
         lce_pkg::MARK_GRAVE: begin
            case (upper)
               7'h41:   comp = 8'hc0;
               7'h45:   comp = 8'hc8;
               7'h49:   comp = 8'hcc;
               7'h4f:   comp = 8'hd2;
               7'h55:   comp = 8'hd9;
               default: found = 1'b0;
            endcase
         end
         lce_pkg::MARK_ACUTE: begin
            case (upper)
               7'h41:   comp = 8'hc1;
               7'h45:   comp = 8'hc9;
               7'h49:   comp = 8'hcd;
               7'h4f:   comp = 8'hd3;
               7'h55:   comp = 8'hda;
               7'h59:   comp = 8'hdd;
               default: found = 1'b0;
            endcase
         end
         lce_pkg::MARK_CIRC: begin
            case (upper)
               7'h41:   comp = 8'hc2;
               7'h45:   comp = 8'hca;
               7'h49:   comp = 8'hce;
               7'h4f:   comp = 8'hd4;
               7'h55:   comp = 8'hdb;
               default: found = 1'b0;
            endcase
         end
         lce_pkg::MARK_TILDE: begin
            case (upper)
               7'h41:   comp = 8'hc3;
               7'h4e:   comp = 8'hd1;
               7'h4f:   comp = 8'hd5;
               default: found = 1'b0;
            endcase
         end
         lce_pkg::MARK_DIAER: begin
            case (upper)
               7'h41:   comp = 8'hc4;
               7'h45:   comp = 8'hcb;
               7'h49:   comp = 8'hcf;
               7'h4f:   comp = 8'hd6;
               7'h55:   comp = 8'hdc;
               // y-diaeresis exists in lowercase only
               7'h59: begin
                  comp  = 8'hdf;
                  found = lower;
               end
               default: found = 1'b0;
            endcase
         end
         lce_pkg::MARK_RING: begin
            if (upper == 7'h41) comp = 8'hc5;
            else found = 1'b0;
         end
         lce_pkg::MARK_CEDIL: begin
            if (upper == 7'h43) comp = 8'hc7;
            else found = 1'b0;
         end
         default: found = 1'b0;
      endcase
      // lowercase letters sit 0x20 above their capitals
      return {found, comp | {2'b00, lower, 5'b00000}};
   endfunction

   logic                                 vld_ff, vld_in;
   logic                                 kind_ff;
   logic [lce_pkg::CP_W-1:0]             cp_ff;
   logic [lce_pkg::HELD_W-1:0]           held_ff, held_in;

   logic                                 go;
   logic                                 have_held;
   logic [8:0]                           lookup;
   logic                                 found;
   logic [lce_pkg::CP_W-1:0]             cp_eff;
   logic                                 hold_new;
   logic                                 emit_held;
   logic                                 emit_main;
   lce_pkg::result_type                  held_res;
   lce_pkg::result_type                  main_res;

   assign go       = vld_ff & room;
   assign in_ready = ~vld_ff | room;

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
      if (in_valid && in_ready) begin
         kind_ff <= in_kind;
         cp_ff   <= in_cp;
      end
   end

   assign vld_in = in_ready ? in_valid : vld_ff;

   // Composition and classification
   assign have_held = (held_ff != lce_pkg::HELD_NONE);
   assign lookup    = compose_lookup(held_ff, cp_ff);
   assign found     = have_held & lookup[8];
   assign cp_eff    = found ? lce_pkg::CP_W'(lookup[7:0]) : cp_ff;
   assign hold_new  = (cp_eff > lce_pkg::CP_SPACE) && (cp_eff < lce_pkg::CP_DEL);

   always_comb begin
      held_res.out_byte = {1'b0, held_ff};
      held_res.status   = lce_pkg::STATUS_OK;
      held_res.last     = 1'b0;

      main_res.out_byte = cp_eff[lce_pkg::BYTE_W-1:0];
      main_res.status   = lce_pkg::STATUS_OK;
      main_res.last     = 1'b1;
      if ((cp_eff > lce_pkg::CP_MAX) || (cp_eff == '0)) begin
         main_res.out_byte = '0;
         main_res.status   = lce_pkg::STATUS_ILLEGAL;
      end

      if (kind_ff == lce_pkg::KIND_FLUSH) begin
         emit_held = have_held;
         emit_main = 1'b0;
         held_in   = lce_pkg::HELD_NONE;
      end else begin
         emit_held = have_held & ~found;
         emit_main = ~hold_new;
         held_in   = hold_new ? cp_eff[lce_pkg::HELD_W-1:0] : lce_pkg::HELD_NONE;
      end
      held_res.last = ~emit_main;

      // Order results: held letter first, then the new character
      push.r0  = emit_held ? held_res : main_res;
      push.r1  = main_res;
      push.cnt = go ? (2'(emit_held) + 2'(emit_main)) : 2'd0;
   end

   // Held letter register
   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff <= lce_pkg::HELD_NONE;
      end else if (go) begin
         held_ff <= held_in;
      end
   end

endmodule

### rtl/lce_outq.sv
// ----------------------------------------------------------------------------
// lce_outq
// Small result queue: takes up to two results per cycle while it has room, returns one.
// ----------------------------------------------------------------------------
module lce_outq (
   input  logic                          clock,
   input  logic                          reset,
   input  lce_pkg::push_type             push,
   output logic                          room,
   output logic                          out_valid,
   input  logic                          out_ready,
   output lce_pkg::result_type           out_res
);

   lce_pkg::result_type                  mem_ff [lce_pkg::QUEUE_DEPTH];
   logic [lce_pkg::PTR_W-1:0]            wr_ptr_ff, wr_ptr_in;
   logic [lce_pkg::PTR_W-1:0]            rd_ptr_ff, rd_ptr_in;
   logic [lce_pkg::CNT_W-1:0]            count_ff, count_in;
   logic [lce_pkg::PTR_W-1:0]            wr_ptr_nxt;
   logic                                 pop;

   assign out_valid  = (count_ff != '0);
   assign out_res    = mem_ff[rd_ptr_ff];
   assign pop        = out_valid & out_ready;
   assign room       = (count_ff <= lce_pkg::CNT_W'(lce_pkg::QUEUE_DEPTH - 2));
   assign wr_ptr_nxt = lce_pkg::PTR_W'(wr_ptr_ff + 1'b1);

   // Pointer and occupancy update
   always_comb begin
      wr_ptr_in = lce_pkg::PTR_W'(wr_ptr_ff + lce_pkg::PTR_W'(push.cnt));
      rd_ptr_in = pop ? lce_pkg::PTR_W'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      count_in  = lce_pkg::CNT_W'(count_ff + lce_pkg::CNT_W'(push.cnt)
                                  - lce_pkg::CNT_W'(pop));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage
   always_ff @(posedge clock) begin
      if (push.cnt != 2'd0) begin
         mem_ff[wr_ptr_ff] <= push.r0;
      end
      if (push.cnt == 2'd2) begin
         mem_ff[wr_ptr_nxt] <= push.r1;
      end
   end

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= lce_pkg::CNT_W'(lce_pkg::QUEUE_DEPTH))
      else $error("result queue overflow");

   a_push_needs_room: assert property (@(posedge clock) disable iff (reset)
      (push.cnt != 2'd0) |-> room)
      else $error("push without room");

   a_pop_only: assert property (@(posedge clock) disable iff (reset)
      (pop && push.cnt == 2'd0) |=> count_ff == lce_pkg::CNT_W'($past(count_ff) - 1'b1))
      else $error("occupancy did not drop on pop");

   a_ptr_gap: assert property (@(posedge clock) disable iff (reset)
      lce_pkg::PTR_W'(rd_ptr_ff + count_ff[lce_pkg::PTR_W-1:0]) == wr_ptr_ff)
      else $error("pointers disagree with occupancy");
`endif

endmodule

### rtl/latin1_composing_encoder_top.sv
// ----------------------------------------------------------------------------
// latin1_composing_encoder_top
// Unicode code point to ISO-8859-1 encoder with base letter + mark composition.
// ----------------------------------------------------------------------------
// One request transaction is accepted per clock. Each request is registered,
// decoded combinationally against the held letter and its zero, one or two
// response bytes are written into a four-entry result queue. The response
// channel carries one byte per cycle while rsp_tready is high, so a request
// that yields two bytes takes two response transactions, and req_tready
// drops while a registered request waits and the queue holds more than two
// results. rsp_tlast marks the final response of each request.
// ----------------------------------------------------------------------------
module latin1_composing_encoder_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // [20:0] code_point, [23:21] zero
   input  logic        req_tuser,   // [0] kind (1 = flush)
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [7:0] out_byte
   output logic        rsp_tuser,   // [0] status (1 = illegal code point)
   output logic        rsp_tlast
);

   lce_pkg::push_type   push;
   lce_pkg::result_type rsp_res;
   logic                room;

   // Decode stage
   lce_decode u_decode (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_tvalid),
      .in_ready (req_tready),
      .in_kind  (req_tuser),
      .in_cp    (req_tdata[lce_pkg::CP_W-1:0]),
      .room     (room),
      .push     (push)
   );

   // Result queue
   lce_outq u_outq (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .room      (room),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_res   (rsp_res)
   );

   assign rsp_tdata = rsp_res.out_byte;
   assign rsp_tuser = rsp_res.status;
   assign rsp_tlast = rsp_res.last;

endmodule

### tb/latin1_stream_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// latin1_stream_checker
// Watches both stream channels of the Latin-1 composing encoder, predicts the
// bytes each accepted request must produce and compares every response.
// ----------------------------------------------------------------------------
// The encoding is tracked from the request side with a private copy of the
// held base letter. Predicted responses wait in order until the response
// channel delivers them; every field of every response is compared.
// ----------------------------------------------------------------------------
module latin1_stream_checker
   import lce_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [23:0] req_tdata,
   input  logic        req_tuser,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [7:0]  rsp_tdata,
   input  logic        rsp_tuser,
   input  logic        rsp_tlast,
   output int          error_count,
   output int          pending_results,
   output int          request_count,
   output int          checked_count,
   output int          flush_count,
   output int          composed_count,
   output int          illegal_count
);

   // Bytes still owed by the encoder, oldest first
   result_type              latin1_results_q[$];
   logic [HELD_W-1:0]       held_base_q;

   initial begin
      error_count     = 0;
      pending_results = 0;
      request_count   = 0;
      checked_count   = 0;
      flush_count     = 0;
      composed_count  = 0;
      illegal_count   = 0;
      held_base_q     = HELD_NONE;
   end

   // Precomposed Latin-1 letter for base + combining mark, 0 when no pair exists
   function automatic logic [7:0] compose_byte(input logic [HELD_W-1:0] base,
                                               input logic [CP_W-1:0] mark);
      logic [7:0] ch;
      ch = {1'b0, base};
      compose_byte = 8'h00;
      case (mark)
         MARK_GRAVE: case (ch)
            "A": compose_byte = 8'hC0;  "E": compose_byte = 8'hC8;
            "I": compose_byte = 8'hCC;  "O": compose_byte = 8'hD2;
            "U": compose_byte = 8'hD9;  "a": compose_byte = 8'hE0;
            "e": compose_byte = 8'hE8;  "i": compose_byte = 8'hEC;
            "o": compose_byte = 8'hF2;  "u": compose_byte = 8'hF9;
            default: ;
         endcase
         MARK_ACUTE: case (ch)
            "A": compose_byte = 8'hC1;  "E": compose_byte = 8'hC9;
            "I": compose_byte = 8'hCD;  "O": compose_byte = 8'hD3;
            "U": compose_byte = 8'hDA;  "Y": compose_byte = 8'hDD;
            "a": compose_byte = 8'hE1;  "e": compose_byte = 8'hE9;
            "i": compose_byte = 8'hED;  "o": compose_byte = 8'hF3;
            "u": compose_byte = 8'hFA;  "y": compose_byte = 8'hFD;
            default: ;
         endcase
         MARK_CIRC: case (ch)
            "A": compose_byte = 8'hC2;  "E": compose_byte = 8'hCA;
            "I": compose_byte = 8'hCE;  "O": compose_byte = 8'hD4;
            "U": compose_byte = 8'hDB;  "a": compose_byte = 8'hE2;
            "e": compose_byte = 8'hEA;  "i": compose_byte = 8'hEE;
            "o": compose_byte = 8'hF4;  "u": compose_byte = 8'hFB;
            default: ;
         endcase
         MARK_TILDE: case (ch)
            "A": compose_byte = 8'hC3;  "N": compose_byte = 8'hD1;
            "O": compose_byte = 8'hD5;  "a": compose_byte = 8'hE3;
            "n": compose_byte = 8'hF1;  "o": compose_byte = 8'hF5;
            default: ;
         endcase
         MARK_DIAER: case (ch)
            "A": compose_byte = 8'hC4;  "E": compose_byte = 8'hCB;
            "I": compose_byte = 8'hCF;  "O": compose_byte = 8'hD6;
            "U": compose_byte = 8'hDC;  "a": compose_byte = 8'hE4;
            "e": compose_byte = 8'hEB;  "i": compose_byte = 8'hEF;
            "o": compose_byte = 8'hF6;  "u": compose_byte = 8'hFC;
            "y": compose_byte = 8'hFF;
            default: ;
         endcase
         MARK_RING: case (ch)
            "A": compose_byte = 8'hC5;  "a": compose_byte = 8'hE5;
            default: ;
         endcase
         MARK_CEDIL: case (ch)
            "C": compose_byte = 8'hC7;  "c": compose_byte = 8'hE7;
            default: ;
         endcase
         default: ;
      endcase
   endfunction

   // Work out the zero, one or two bytes caused by one request transaction
   task automatic predict_encoding(input logic kind, input logic [CP_W-1:0] cp);
      logic [BYTE_W-1:0] out_bytes[2];
      logic              out_status[2];
      logic [BYTE_W-1:0] composed;
      logic [CP_W-1:0]   cur;
      result_type        item;
      int                n;
      n   = 0;
      cur = cp;
      request_count++;
      if (kind == KIND_FLUSH) begin
         flush_count++;
         if (held_base_q != HELD_NONE) begin
            out_bytes[n]  = {1'b0, held_base_q};
            out_status[n] = STATUS_OK;
            n++;
            held_base_q = HELD_NONE;
         end
      end else begin
         // A held letter either merges with this mark or goes out on its own
         if (held_base_q != HELD_NONE) begin
            composed = compose_byte(held_base_q, cp);
            if (composed != 8'h00) begin
               cur = {{(CP_W-BYTE_W){1'b0}}, composed};
               composed_count++;
            end else begin
               out_bytes[n]  = {1'b0, held_base_q};
               out_status[n] = STATUS_OK;
               n++;
            end
            held_base_q = HELD_NONE;
         end
         if (cur > CP_SPACE && cur < CP_DEL) begin
            held_base_q = cur[HELD_W-1:0];
         end else if (cur > CP_MAX || cur == '0) begin
            out_bytes[n]  = 8'h00;
            out_status[n] = STATUS_ILLEGAL;
            n++;
            illegal_count++;
         end else begin
            out_bytes[n]  = cur[BYTE_W-1:0];
            out_status[n] = STATUS_OK;
            n++;
         end
      end
      for (int i = 0; i < n; i++) begin
         item.out_byte = out_bytes[i];
         item.status   = out_status[i];
         item.last     = (i == n - 1);
         latin1_results_q.push_back(item);
      end
   endtask

   // Compare one response transaction with the oldest predicted byte
   task automatic check_response();
      result_type want;
      if (latin1_results_q.size() == 0) begin
         error_count++;
         $display("%0t: response with nothing expected: byte %02h status %0b last %0b",
                  $time, rsp_tdata, rsp_tuser, rsp_tlast);
      end else begin
         want = latin1_results_q.pop_front();
         checked_count++;
         if (rsp_tdata !== want.out_byte) begin
            error_count++;
            $display("%0t: out_byte mismatch, expected %02h, got %02h",
                     $time, want.out_byte, rsp_tdata);
         end
         if (rsp_tuser !== want.status) begin
            error_count++;
            $display("%0t: status mismatch, expected %0b, got %0b",
                     $time, want.status, rsp_tuser);
         end
         if (rsp_tlast !== want.last) begin
            error_count++;
            $display("%0t: last mismatch, expected %0b, got %0b",
                     $time, want.last, rsp_tlast);
         end
      end
   endtask

   // Both channels sampled at the edge where a transaction completes
   always @(posedge clock) begin
      if (reset) begin
         latin1_results_q.delete();
         held_base_q = HELD_NONE;
         pending_results <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) check_response();
         if (req_tvalid && req_tready) predict_encoding(req_tuser, req_tdata[CP_W-1:0]);
         pending_results <= latin1_results_q.size();
      end
   end

endmodule

### tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the Latin-1 composing encoder.
// ----------------------------------------------------------------------------
// Drives a directed set of corner cases, then three random phases with
// different idle patterns on the request and response sides. Random traffic
// is mostly base letters followed by combining marks, mixed with plain
// characters, flushes, control bytes and out-of-range code points. One
// long response hold-off fills the encoder so that it stalls its input.
// ----------------------------------------------------------------------------
module tb_top;
   import lce_pkg::*;

   localparam int CLK_HALF        = 4;
   localparam int RESET_CYCLES    = 8;
   localparam int PHASE_ITEMS     = 510;
   localparam int HOLD_OFF_CYCLES = 80;
   localparam int SETTLE_CYCLES   = 10;
   localparam int WATCHDOG_LIMIT  = 2000;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata  = '0;   // [20:0] code_point, [23:21] zero
   logic        req_tuser  = 1'b0; // [0] kind
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;         // [7:0] out_byte
   logic        rsp_tuser;         // [0] status
   logic        rsp_tlast;

   int  error_count;
   int  pending_results;
   int  request_count;
   int  checked_count;
   int  flush_count;
   int  composed_count;
   int  illegal_count;

   int  send_idle_pct = 0;
   int  recv_idle_pct = 0;
   bit  hold_off_req  = 1'b0;
   int  quiet_cycles  = 0;

   string base_letters = "ACEINOUYaceinouy";

   latin1_composing_encoder_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   latin1_stream_checker checker_i (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .req_tuser       (req_tuser),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .rsp_tuser       (rsp_tuser),
      .rsp_tlast       (rsp_tlast),
      .error_count     (error_count),
      .pending_results (pending_results),
      .request_count   (request_count),
      .checked_count   (checked_count),
      .flush_count     (flush_count),
      .composed_count  (composed_count),
      .illegal_count   (illegal_count)
   );

   // Clock
   initial begin
      forever #(CLK_HALF) clock = ~clock;
   end

   // Response side: random stalls, plus one long hold-off on request
   initial begin
      int hold_left;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (hold_off_req && hold_left == 0) begin
            hold_left = HOLD_OFF_CYCLES;
            hold_off_req <= 1'b0;
         end
         if (reset) begin
            rsp_tready <= 1'b0;
         end else if (hold_left > 0) begin
            rsp_tready <= 1'b0;
            hold_left--;
         end else begin
            rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   // Watchdog: ends the run when no transaction moves for too long
   initial begin
      forever begin
         @(posedge clock);
         if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog expired, %0d responses still expected",
                     $time, pending_results);
            $display("DONE: errors detected");
            $finish;
         end
      end
   end

   function automatic logic [CP_W-1:0] mark_at(input int idx);
      case (idx)
         0:       mark_at = MARK_GRAVE;
         1:       mark_at = MARK_ACUTE;
         2:       mark_at = MARK_CIRC;
         3:       mark_at = MARK_TILDE;
         4:       mark_at = MARK_DIAER;
         5:       mark_at = MARK_RING;
         default: mark_at = MARK_CEDIL;
      endcase
   endfunction

   function automatic logic [CP_W-1:0] boundary_at(input int idx);
      case (idx)
         0:       boundary_at = '0;
         1:       boundary_at = CP_W'(1);
         2:       boundary_at = CP_SPACE;
         3:       boundary_at = CP_W'(CP_SPACE + 1);
         4:       boundary_at = CP_W'(CP_DEL - 1);
         5:       boundary_at = CP_DEL;
         6:       boundary_at = CP_MAX;
         7:       boundary_at = CP_W'(CP_MAX + 1);
         default: boundary_at = '1;
      endcase
   endfunction

   // Offer one request transaction and wait until it is taken
   task automatic send_item(input logic kind, input logic [CP_W-1:0] cp);
      req_tuser  <= kind;
      req_tdata  <= {3'b000, cp};
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      // each following cycle idles with the sender's idle odds
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
   endtask

   // Stop offering and wait for every predicted byte to come out
   task automatic drain_encoder();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_results != 0) @(posedge clock);
   endtask

   // One random step; returns the number of requests it sent
   task automatic send_random_step(output int sent);
      int pick;
      pick = $urandom_range(99);
      sent = 1;
      if (pick < 40) begin
         // base letter followed by a mark that may or may not pair with it
         send_item(KIND_CHAR, CP_W'(base_letters[$urandom_range(15)]));
         send_item(KIND_CHAR, mark_at($urandom_range(6)));
         sent = 2;
      end else if (pick < 55)
         send_item(KIND_CHAR, CP_W'($urandom_range(33, 126)));
      else if (pick < 63)
         send_item(KIND_CHAR, mark_at($urandom_range(6)));
      else if (pick < 71)
         send_item(KIND_FLUSH, CP_W'($urandom));
      else if (pick < 81)
         send_item(KIND_CHAR, CP_W'($urandom_range(0, 255)));
      else if (pick < 91)
         send_item(KIND_CHAR, CP_W'($urandom));
      else
         send_item(KIND_CHAR, boundary_at($urandom_range(8)));
   endtask

   task automatic run_random_phase(input int count);
      int sent;
      int done_items;
      done_items = 0;
      while (done_items < count) begin
         send_random_step(sent);
         done_items += sent;
      end
   endtask

   // Stimulus
   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_idle_pct = 34;
      recv_idle_pct = 50;

      // Directed corner cases
      send_item(KIND_FLUSH, '0);                // flush with nothing held
      send_item(KIND_CHAR, CP_W'("A"));
      send_item(KIND_CHAR, MARK_GRAVE);         // composes to 0xC0
      send_item(KIND_CHAR, CP_W'("y"));
      send_item(KIND_CHAR, MARK_DIAER);         // composes to 0xFF
      send_item(KIND_CHAR, CP_W'("C"));
      send_item(KIND_CHAR, MARK_CEDIL);         // composes to 0xC7
      send_item(KIND_CHAR, CP_W'("A"));
      send_item(KIND_CHAR, MARK_CEDIL);         // no pair: letter, then illegal
      send_item(KIND_CHAR, CP_W'(CP_SPACE + 1));
      send_item(KIND_FLUSH, '1);                // flush emits held letter
      send_item(KIND_CHAR, CP_W'(CP_DEL - 1));
      send_item(KIND_CHAR, CP_SPACE);           // held letter, then space
      send_item(KIND_CHAR, '0);                 // code point zero is illegal
      send_item(KIND_CHAR, CP_W'(1));
      send_item(KIND_CHAR, CP_DEL);
      send_item(KIND_CHAR, CP_MAX);
      send_item(KIND_CHAR, CP_W'(CP_MAX + 1));
      send_item(KIND_CHAR, '1);
      send_item(KIND_CHAR, CP_W'("a"));
      send_item(KIND_CHAR, CP_W'("b"));         // letter replaces letter
      send_item(KIND_CHAR, CP_W'(8'hE9));       // plain Latin-1 byte after letter
      send_item(KIND_CHAR, CP_W'("x"));
      send_item(KIND_CHAR, '0);                 // letter, then illegal
      send_item(KIND_CHAR, MARK_RING);          // lone mark is illegal
      drain_encoder();

      // Random phases with shifting idle patterns
      run_random_phase(PHASE_ITEMS);
      drain_encoder();

      send_idle_pct = 50;
      recv_idle_pct = 34;
      run_random_phase(PHASE_ITEMS);
      drain_encoder();

      // No idling; response side holds off so the encoder backs up
      send_idle_pct = 0;
      recv_idle_pct = 0;
      hold_off_req <= 1'b1;
      run_random_phase(PHASE_ITEMS);
      drain_encoder();

      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Covered %0d requests (%0d flushes), %0d responses checked,",
               request_count, flush_count, checked_count);
      $display("%0d composed letters, %0d illegal code points, one %0d-cycle hold-off.",
               composed_count, illegal_count, HOLD_OFF_CYCLES);
      if (pending_results != 0)
         $display("%0t: %0d expected responses never arrived", $time, pending_results);
      if (error_count == 0 && pending_results == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
